// File: rtl/ssdpst_pkg.sv
`default_nettype none
package ssdpst_pkg;

    localparam int unsigned TARGET_COUNT = 5;
    localparam int unsigned LINE_POS_W   = 2;
    localparam int unsigned VALUE_POS_W  = 5;
    localparam int unsigned TYPE_W       = 2;

    localparam logic [LINE_POS_W-1:0]  PREFIX_LEN    = 2'd3;
    localparam logic [VALUE_POS_W-1:0] VALUE_POS_MAX = 5'd31;

    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_LF      = 8'h0A;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_S = 8'h73;
    localparam logic [7:0] CHAR_LOWER_T = 8'h74;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // Search targets, lower case, first character at index 0, zero padded.
    localparam logic [0:31][7:0] TGT_TEXT [TARGET_COUNT] = '{
        {"urn:", 48'h62656c6b696e, ":device:**", 96'h0},
        {"urn:", 48'h62656c6b696e, ":device:controllee:1", 16'h0},
        {"upnp:rootdevice", 136'h0},
        {"ssdp:all", 192'h0},
        {"ssdpsearch:all", 144'h0}
    };

    localparam logic [VALUE_POS_W-1:0] TGT_LEN [TARGET_COUNT] = '{
        5'd20, 5'd30, 5'd15, 5'd8, 5'd14
    };

    localparam logic [TYPE_W-1:0] TYPE_NONE       = 2'd0;
    localparam logic [TYPE_W-1:0] TYPE_VENDOR_ALL = 2'd1;
    localparam logic [TYPE_W-1:0] TYPE_ROOT_ALL   = 2'd2;
    localparam logic [TYPE_W-1:0] TYPE_CONTROLLEE = 2'd3;

    localparam logic [TYPE_W-1:0] TGT_TYPE [TARGET_COUNT] = '{
        TYPE_VENDOR_ALL, TYPE_CONTROLLEE, TYPE_ROOT_ALL, TYPE_ROOT_ALL, TYPE_ROOT_ALL
    };

    typedef struct packed {
        logic       valid;
        logic [7:0] text_byte;
        logic       is_last;
    } stage_item_t;

    typedef struct packed {
        logic                    scan_stopped;
        logic [LINE_POS_W-1:0]   line_position;
        logic                    line_is_lone_cr;
        logic                    target_line;
        logic                    value_begun;
        logic                    trailing_gap;
        logic [VALUE_POS_W-1:0]  value_position;
        logic [TARGET_COUNT-1:0] candidate_alive;
        logic                    header_seen;
        logic                    duplicate_found;
        logic [TYPE_W-1:0]       found_type;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{
        scan_stopped:    1'b0,
        line_position:   '0,
        line_is_lone_cr: 1'b0,
        target_line:     1'b0,
        value_begun:     1'b0,
        trailing_gap:    1'b0,
        value_position:  '0,
        candidate_alive: '1,
        header_seen:     1'b0,
        duplicate_found: 1'b0,
        found_type:      TYPE_NONE
    };

endpackage
`default_nettype wire

// File: rtl/ssdpst_in_if.sv
`default_nettype none
interface ssdpst_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       is_last;

    modport source (output valid, output text_byte, output is_last, input ready);
    modport sink   (input valid, input text_byte, input is_last, output ready);
endinterface
`default_nettype wire

// File: rtl/ssdpst_out_if.sv
`default_nettype none
interface ssdpst_out_if;
    logic                           valid;
    logic                           ready;
    logic [ssdpst_pkg::TYPE_W-1:0]  search_type;

    modport source (output valid, output search_type, input ready);
    modport sink   (input valid, input search_type, output ready);
endinterface
`default_nettype wire

// File: rtl/ssdpst_in_reg.sv
`default_nettype none
module ssdpst_in_reg (
    input  wire logic               clk,
    input  wire logic               rst_n,
    ssdpst_in_if.sink               byte_stream,
    input  wire logic               advance,
    output ssdpst_pkg::stage_item_t item
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       take;

    // Take a new byte when the stage is empty or its byte moves on now.
    assign byte_stream.ready = !valid_reg || advance;
    assign take = byte_stream.valid && byte_stream.ready;

    always_comb
    begin
        priority if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= byte_stream.text_byte;
            last_reg <= byte_stream.is_last;
        end
    end

    assign item.valid     = valid_reg;
    assign item.text_byte = byte_reg;
    assign item.is_last   = last_reg;

endmodule
`default_nettype wire

// File: rtl/ssdpst_scan.sv
`default_nettype none
module ssdpst_scan (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  ssdpst_pkg::stage_item_t            item,
    input  wire logic                          advance,
    output logic [ssdpst_pkg::TYPE_W-1:0]      result_type
);

    ssdpst_pkg::scan_state_t state_reg;
    ssdpst_pkg::scan_state_t state_next;

    function automatic logic [7:0] fold(input logic [7:0] b);
        if (b >= ssdpst_pkg::CHAR_UPPER_A && b <= ssdpst_pkg::CHAR_UPPER_Z)
            return b + ssdpst_pkg::CASE_OFFSET;
        return b;
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return b == ssdpst_pkg::CHAR_SPACE || b == ssdpst_pkg::CHAR_TAB ||
               b == ssdpst_pkg::CHAR_CR;
    endfunction

    function automatic ssdpst_pkg::scan_state_t clear_line(
        input ssdpst_pkg::scan_state_t s);
        ssdpst_pkg::scan_state_t n;
        n = s;
        n.line_position   = '0;
        n.line_is_lone_cr = 1'b0;
        n.target_line     = 1'b0;
        n.value_begun     = 1'b0;
        n.trailing_gap    = 1'b0;
        n.value_position  = '0;
        n.candidate_alive = '1;
        return n;
    endfunction

    // Commit the first surviving target of full length, then drop the line.
    function automatic ssdpst_pkg::scan_state_t finish_line(
        input ssdpst_pkg::scan_state_t s);
        ssdpst_pkg::scan_state_t n;
        logic hit;
        n   = s;
        hit = 1'b0;
        if (s.target_line && s.line_position == ssdpst_pkg::PREFIX_LEN &&
            !s.duplicate_found)
        begin
            for (int k = 0; k < ssdpst_pkg::TARGET_COUNT; k++)
            begin
                if (!hit && s.candidate_alive[k] &&
                    s.value_position == ssdpst_pkg::TGT_LEN[k])
                begin
                    n.found_type = ssdpst_pkg::TGT_TYPE[k];
                    hit = 1'b1;
                end
            end
        end
        return clear_line(n);
    endfunction

    function automatic ssdpst_pkg::scan_state_t value_byte(
        input ssdpst_pkg::scan_state_t s, input logic [7:0] b);
        ssdpst_pkg::scan_state_t n;
        logic [7:0] fb;
        n  = s;
        fb = fold(b);
        if (is_blank(b))
        begin
            if (s.value_begun)
                n.trailing_gap = 1'b1;
        end
        else
        begin
            // A blank inside the value rules out every target.
            if (s.trailing_gap)
                n.candidate_alive = '0;
            n.value_begun = 1'b1;
            for (int k = 0; k < ssdpst_pkg::TARGET_COUNT; k++)
            begin
                if (s.value_position >= ssdpst_pkg::TGT_LEN[k] ||
                    ssdpst_pkg::TGT_TEXT[k][s.value_position] != fb)
                    n.candidate_alive[k] = 1'b0;
            end
            if (s.value_position < ssdpst_pkg::VALUE_POS_MAX)
                n.value_position = s.value_position + 1'b1;
        end
        return n;
    endfunction

    function automatic ssdpst_pkg::scan_state_t take_byte(
        input ssdpst_pkg::scan_state_t s, input logic [7:0] b);
        ssdpst_pkg::scan_state_t n;
        n = s;
        if (s.line_position < ssdpst_pkg::PREFIX_LEN)
        begin
            if (s.line_position == '0)
            begin
                n.target_line     = fold(b) == ssdpst_pkg::CHAR_LOWER_S;
                n.line_is_lone_cr = b == ssdpst_pkg::CHAR_CR;
            end
            else
            begin
                n.line_is_lone_cr = 1'b0;
                if (s.line_position == 2'd1)
                    n.target_line = s.target_line && fold(b) == ssdpst_pkg::CHAR_LOWER_T;
                else
                    n.target_line = s.target_line && b == ssdpst_pkg::CHAR_COLON;
            end
            n.line_position = s.line_position + 1'b1;
            if (n.line_position == ssdpst_pkg::PREFIX_LEN && n.target_line)
            begin
                // Second ST line: flag the duplicate and stop scanning.
                if (s.header_seen)
                begin
                    n.duplicate_found = 1'b1;
                    n.scan_stopped    = 1'b1;
                end
                n.header_seen = 1'b1;
            end
        end
        else if (s.target_line)
        begin
            n = value_byte(s, b);
        end
        return n;
    endfunction

    ssdpst_pkg::scan_state_t after_byte;
    ssdpst_pkg::scan_state_t at_end;

    always_comb
    begin
        after_byte = state_reg;
        if (!state_reg.scan_stopped)
        begin
            priority if (item.text_byte == ssdpst_pkg::CHAR_NUL)
            begin
                after_byte = finish_line(state_reg);
                after_byte.scan_stopped = 1'b1;
            end
            else if (item.text_byte == ssdpst_pkg::CHAR_LF)
            begin
                if (state_reg.line_position == '0 ||
                    (state_reg.line_position == 2'd1 && state_reg.line_is_lone_cr))
                begin
                    after_byte = clear_line(state_reg);
                    after_byte.scan_stopped = 1'b1;
                end
                else
                begin
                    after_byte = finish_line(state_reg);
                end
            end
            else
            begin
                after_byte = take_byte(state_reg, item.text_byte);
            end
        end

        at_end = after_byte.scan_stopped ? after_byte : finish_line(after_byte);
        result_type = at_end.duplicate_found ? ssdpst_pkg::TYPE_NONE : at_end.found_type;

        // The last byte of a packet returns the scanner to its reset state.
        state_next = item.is_last ? ssdpst_pkg::SCAN_RESET : after_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ssdpst_pkg::SCAN_RESET;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/ssdp_search_target_classifier.sv
// Result path: the last byte is held in the input register, then its type
//   is loaded into the result register; a full result register can hold it.
// Throughput: one header byte per cycle, unless a last byte waits on a full
//   result register; one result per packet, on the byte flagged last.
// Reset: rst_n is asynchronous, active low; it empties both stages and
//   returns the scanner to its idle state at once. There is no clearing pass.
`default_nettype none
module ssdp_search_target_classifier (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ssdpst_in_if.sink   byte_stream,
    ssdpst_out_if.source result
);

    ssdpst_pkg::stage_item_t            item;
    logic                               advance;
    logic [ssdpst_pkg::TYPE_W-1:0]      result_type;

    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [ssdpst_pkg::TYPE_W-1:0]      type_reg;

    // A byte held in the input register moves on when it causes no result,
    // or when the result register is empty or its transaction completes now.
    // The result register thus parts the two sides: input keeps flowing while
    // a finished type waits to be taken, unless another last byte arrives.
    assign advance = item.valid &&
                     (!item.is_last || !out_valid_reg || result.ready);

    // Input register: capture one byte per transaction.
    ssdpst_in_reg u_in_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_stream),
        .advance     (advance),
        .item        (item)
    );

    // Line splitting, prefix check, value trim and target match.
    ssdpst_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .advance     (advance),
        .result_type (result_type)
    );

    // Result register: load on a last byte, drop after the transaction.
    always_comb
    begin
        priority if (advance && item.is_last)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item.is_last)
        begin
            type_reg <= result_type;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.search_type = type_reg;

endmodule
`default_nettype wire

// File: dv/ssdpst_target_checker.sv
`default_nettype none
module ssdpst_target_checker
    import ssdpst_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    ssdpst_in_if      byte_mon,
    ssdpst_out_if     type_mon,
    output int        fail_count,
    output int        open_count
);

    localparam int unsigned TARGET_TOTAL = 5;
    localparam logic [1:0]  PREFIX_DONE  = 2'd3;
    localparam logic [4:0]  VALUE_CAP    = 5'd31;

    localparam logic [7:0] ASCII_NUL   = 8'h00;
    localparam logic [7:0] ASCII_TAB   = 8'h09;
    localparam logic [7:0] ASCII_LF    = 8'h0A;
    localparam logic [7:0] ASCII_CR    = 8'h0D;
    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_COLON = 8'h3A;
    localparam logic [7:0] ASCII_S     = 8'h73;
    localparam logic [7:0] ASCII_T     = 8'h74;

    // Known targets, lower case, zero padded to 32 characters.
    localparam logic [0:31][7:0] KNOWN_TEXT [TARGET_TOTAL] = '{
        {"urn:", 48'h62656c6b696e, ":device:**", 96'h0},
        {"urn:", 48'h62656c6b696e, ":device:controllee:1", 16'h0},
        {"upnp:rootdevice", 136'h0},
        {"ssdp:all", 192'h0},
        {"ssdpsearch:all", 144'h0}
    };
    localparam logic [4:0] KNOWN_LEN [TARGET_TOTAL] = '{
        5'd20, 5'd30, 5'd15, 5'd8, 5'd14
    };
    localparam logic [1:0] KNOWN_KIND [TARGET_TOTAL] = '{
        TYPE_VENDOR_ALL, TYPE_CONTROLLEE, TYPE_ROOT_ALL, TYPE_ROOT_ALL, TYPE_ROOT_ALL
    };

    scan_state_t scan;
    logic [1:0]  predicted_types [$];
    logic [1:0]  expected_type;
    int          errors;

    function automatic logic [7:0] lower_case(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A)
            return c + 8'h20;
        return c;
    endfunction

    function automatic void wipe_line();
        scan.line_position   = '0;
        scan.line_is_lone_cr = 1'b0;
        scan.target_line     = 1'b0;
        scan.value_begun     = 1'b0;
        scan.trailing_gap    = 1'b0;
        scan.value_position  = '0;
        scan.candidate_alive = '1;
    endfunction

    function automatic void fresh_packet();
        scan.scan_stopped    = 1'b0;
        scan.header_seen     = 1'b0;
        scan.duplicate_found = 1'b0;
        scan.found_type      = TYPE_NONE;
        wipe_line();
    endfunction

    // Take the first surviving target whose length equals the value length.
    function automatic void close_line();
        logic hit;
        hit = 1'b0;
        if (scan.target_line && scan.line_position == PREFIX_DONE && !scan.duplicate_found)
        begin
            for (int k = 0; k < TARGET_TOTAL; k++)
            begin
                if (!hit && scan.candidate_alive[k] && scan.value_position == KNOWN_LEN[k])
                begin
                    scan.found_type = KNOWN_KIND[k];
                    hit = 1'b1;
                end
            end
        end
        wipe_line();
    endfunction

    function automatic void take_value_char(input logic [7:0] c);
        if (c == ASCII_SPACE || c == ASCII_TAB || c == ASCII_CR)
        begin
            if (scan.value_begun)
                scan.trailing_gap = 1'b1;
        end
        else
        begin
            // A blank between value characters rules out every target.
            if (scan.trailing_gap)
                scan.candidate_alive = '0;
            scan.value_begun = 1'b1;
            for (int k = 0; k < TARGET_TOTAL; k++)
            begin
                if (scan.candidate_alive[k] &&
                    (scan.value_position >= KNOWN_LEN[k] ||
                     KNOWN_TEXT[k][scan.value_position] != lower_case(c)))
                    scan.candidate_alive[k] = 1'b0;
            end
            if (scan.value_position < VALUE_CAP)
                scan.value_position++;
        end
    endfunction

    function automatic void take_line_char(input logic [7:0] c);
        if (scan.line_position < PREFIX_DONE)
        begin
            if (scan.line_position == 2'd0)
            begin
                scan.target_line     = (lower_case(c) == ASCII_S);
                scan.line_is_lone_cr = (c == ASCII_CR);
            end
            else
            begin
                scan.line_is_lone_cr = 1'b0;
                if (scan.line_position == 2'd1)
                    scan.target_line = scan.target_line && (lower_case(c) == ASCII_T);
                else
                    scan.target_line = scan.target_line && (c == ASCII_COLON);
            end
            scan.line_position++;
            if (scan.line_position == PREFIX_DONE && scan.target_line)
            begin
                if (scan.header_seen)
                begin
                    scan.duplicate_found = 1'b1;
                    scan.scan_stopped    = 1'b1;
                end
                scan.header_seen = 1'b1;
            end
        end
        else if (scan.target_line)
        begin
            take_value_char(c);
        end
    endfunction

    function automatic void classify_byte(input logic [7:0] c, input logic last);
        if (!scan.scan_stopped)
        begin
            if (c == ASCII_NUL)
            begin
                close_line();
                scan.scan_stopped = 1'b1;
            end
            else if (c == ASCII_LF)
            begin
                if (scan.line_position == 2'd0 ||
                    (scan.line_position == 2'd1 && scan.line_is_lone_cr))
                begin
                    wipe_line();
                    scan.scan_stopped = 1'b1;
                end
                else
                begin
                    close_line();
                end
            end
            else
            begin
                take_line_char(c);
            end
        end
        if (last)
        begin
            if (!scan.scan_stopped)
                close_line();
            predicted_types.push_back(scan.duplicate_found ? TYPE_NONE : scan.found_type);
            fresh_packet();
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_packet();
            predicted_types.delete();
            errors = 0;
            fail_count <= 0;
            open_count <= 0;
        end
        else
        begin
            if (byte_mon.valid && byte_mon.ready)
                classify_byte(byte_mon.text_byte, byte_mon.is_last);
            if (type_mon.valid && type_mon.ready)
            begin
                if (predicted_types.size() == 0)
                begin
                    errors++;
                    $error("search_type: expected nothing, actual %0d", type_mon.search_type);
                end
                else
                begin
                    expected_type = predicted_types.pop_front();
                    if (type_mon.search_type !== expected_type)
                    begin
                        errors++;
                        $error("search_type: expected %0d, actual %0d",
                               expected_type, type_mon.search_type);
                    end
                end
            end
            fail_count <= errors;
            open_count <= predicted_types.size();
        end
    end

endmodule
`default_nettype wire

// File: dv/ssdp_search_target_classifier_tb.sv
`default_nettype none
module ssdp_search_target_classifier_tb;
    import ssdpst_pkg::*;

    // Hard stop for a hung run; far beyond the slowest legal run.
    localparam int unsigned RUN_LIMIT          = 600000;
    // Random phase stops once both of these are reached.
    localparam int unsigned RANDOM_BYTES_MIN   = 440;
    localparam int unsigned RANDOM_PACKETS_MIN = 10;
    // Long hold-off on the result side, to back up the block into its input.
    localparam int unsigned SQUEEZE_CYCLES     = 400;
    // Cycles to wait after the last expected result before the verdict.
    localparam int unsigned DRAIN_TAIL         = 16;

    typedef enum int unsigned {DRAIN_OPEN, DRAIN_CHOPPY, DRAIN_SHUT} drain_mode_e;
    typedef enum int unsigned {
        EDIT_NONE, EDIT_TRUNCATE, EDIT_EXTEND, EDIT_REPLACE, EDIT_SPLIT, EDIT_GARBLE
    } value_edit_e;

    logic clk;
    logic rst_n;

    ssdpst_in_if  byte_stream ();
    ssdpst_out_if result ();

    int          fail_count;
    int          open_count;
    bit          random_phase;
    logic [7:0]  pkt [$];
    int unsigned burst_left;
    int unsigned random_bytes;
    int unsigned random_packets;

    ssdp_search_target_classifier dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_stream),
        .result      (result)
    );

    // Watch both channels, predict each packet's search type and compare.
    ssdpst_target_checker verdict_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_mon   (byte_stream),
        .type_mon   (result),
        .fail_count (fail_count),
        .open_count (open_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Packet building helpers. Each packet is assembled in pkt and then
    // streamed out byte by byte; the final byte carries is_last.
    // ------------------------------------------------------------------

    // Flip a lower case letter to upper case half of the time.
    function automatic logic [7:0] mixed_case(input logic [7:0] c);
        if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1)
            return c - CASE_OFFSET;
        return c;
    endfunction

    function automatic logic [7:0] printable();
        return 8'($urandom_range(33, 126));
    endfunction

    function automatic logic [7:0] blank_char(input bit allow_cr);
        case ($urandom_range(0, allow_cr ? 2 : 1))
            0:       return CHAR_SPACE;
            1:       return CHAR_TAB;
            default: return CHAR_CR;
        endcase
    endfunction

    // Any byte that neither ends the line nor the header text.
    function automatic logic [7:0] line_byte();
        logic [7:0] b;
        b = 8'($urandom_range(1, 255));
        return (b == CHAR_LF) ? CHAR_SPACE : b;
    endfunction

    function automatic void add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            pkt.push_back(s[i]);
    endfunction

    function automatic void add_crlf();
        pkt.push_back(CHAR_CR);
        pkt.push_back(CHAR_LF);
    endfunction

    function automatic void add_target(input int unsigned k);
        for (int i = 0; i < TGT_LEN[k]; i++)
            pkt.push_back(mixed_case(TGT_TEXT[k][i]));
    endfunction

    // ST line: random-case prefix (rarely broken), padded value that is
    // either a target as is or a target with one edit applied.
    function automatic void add_search_line();
        logic [7:0]  value [$];
        value_edit_e edit;
        int unsigned k;
        int unsigned n;
        int unsigned pos;
        pkt.push_back(mixed_case("s"));
        pkt.push_back(mixed_case("t"));
        pkt.push_back(($urandom_range(0, 15) == 0) ? printable() : CHAR_COLON);
        repeat ($urandom_range(0, 2)) pkt.push_back(blank_char(1'b0));
        k = $urandom_range(0, TARGET_COUNT - 1);
        for (int i = 0; i < TGT_LEN[k]; i++)
            value.push_back(mixed_case(TGT_TEXT[k][i]));
        edit = ($urandom_range(0, 1) == 1) ? EDIT_NONE : value_edit_e'($urandom_range(1, 5));
        case (edit)
            EDIT_TRUNCATE:
            begin
                n = $urandom_range(1, 3);
                repeat (n) void'(value.pop_back());
            end
            EDIT_EXTEND:
                value.push_back(printable());
            EDIT_REPLACE:
            begin
                pos = $urandom_range(0, value.size() - 1);
                value[pos] = printable();
            end
            EDIT_SPLIT:
            begin
                pos = $urandom_range(1, value.size() - 1);
                value.insert(pos, blank_char(1'b1));
            end
            EDIT_GARBLE:
            begin
                // Includes values long enough to saturate the position.
                value.delete();
                n = $urandom_range(0, 40);
                repeat (n) value.push_back(printable());
            end
            default: ;
        endcase
        foreach (value[i])
            pkt.push_back(value[i]);
        repeat ($urandom_range(0, 2)) pkt.push_back(blank_char(1'b1));
    endfunction

    function automatic void add_other_line();
        repeat ($urandom_range(0, 14)) pkt.push_back(line_byte());
    endfunction

    // Mostly well-formed headers with random content; some pure noise.
    function automatic void build_random_packet();
        int unsigned lines;
        pkt.delete();
        if ($urandom_range(0, 99) < 15)
        begin
            repeat ($urandom_range(1, 24)) pkt.push_back(8'($urandom));
        end
        else
        begin
            lines = $urandom_range(1, 3);
            for (int j = 0; j < lines; j++)
            begin
                if ($urandom_range(0, 9) < 5)
                    add_search_line();
                else
                    add_other_line();
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5, 6: add_crlf();
                    7, 8:                pkt.push_back(CHAR_LF);
                    default:             ;
                endcase
            end
            case ($urandom_range(0, 5))
                0, 1: add_crlf();
                2:    pkt.push_back(CHAR_LF);
                3:
                begin
                    pkt.push_back(CHAR_NUL);
                    repeat ($urandom_range(0, 5)) pkt.push_back(8'($urandom));
                end
                default: ;
            endcase
        end
        if (pkt.size() == 0)
            pkt.push_back(line_byte());
    endfunction

    // ------------------------------------------------------------------
    // Byte sender: bursts of random length, random idle gaps between them.
    // ------------------------------------------------------------------
    task automatic offer_byte(input logic [7:0] b, input logic last);
        int unsigned idle;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            idle = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
            if (idle != 0)
            begin
                // Drop valid and scramble the payload while idle.
                byte_stream.valid     <= 1'b0;
                byte_stream.text_byte <= 8'($urandom);
                byte_stream.is_last   <= 1'($urandom);
                repeat (idle) @(posedge clk);
            end
        end
        burst_left--;
        byte_stream.valid     <= 1'b1;
        byte_stream.text_byte <= b;
        byte_stream.is_last   <= last;
        // Hold the transaction until the block takes it.
        @(posedge clk);
        while (!byte_stream.ready) @(posedge clk);
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt.size(); i++)
            offer_byte(pkt[i], i == pkt.size() - 1);
    endtask

    // ------------------------------------------------------------------
    // Directed packets: each target, case folding, trimming, stops,
    // duplicates and the field extremes.
    // ------------------------------------------------------------------
    task automatic run_directed();
        // Plain match, stopped by a lone CR line.
        pkt.delete(); add_str("ST: ssdp:all"); add_crlf(); add_crlf(); send_packet();
        // Vendor target in a line without a line feed.
        pkt.delete(); add_str("st:"); add_target(0); send_packet();
        // Controllee with tab and trailing space.
        pkt.delete(); add_str("sT:"); pkt.push_back(CHAR_TAB); add_target(1);
        pkt.push_back(CHAR_SPACE); add_crlf(); send_packet();
        // Second ST line forces zero.
        pkt.delete(); add_str("ST: upnp:rootdevice"); add_crlf();
        add_str("ST: ssdp:all"); add_crlf(); send_packet();
        // Blank inside the value.
        pkt.delete(); add_str("ST: ssdp :all"); add_crlf(); send_packet();
        // Overlong value saturates the position.
        pkt.delete(); add_str("ST: ssdpsearch:all0123456789abcdefghij"); add_crlf();
        send_packet();
        pkt.delete(); add_str("ST: ssdpsearch:all"); add_crlf(); send_packet();
        // Zero byte ends the text; the tail is ignored.
        pkt.delete(); add_str("ST: UPNP:ROOTDEVICE"); pkt.push_back(CHAR_NUL);
        add_str("ST: x"); send_packet();
        // Empty line before the ST line stops the scan.
        pkt.delete(); add_str("HOST: a"); add_crlf(); add_crlf();
        add_str("ST: ssdp:all"); pkt.push_back(CHAR_LF); send_packet();
        pkt.delete(); pkt.push_back(CHAR_LF); add_str("ST: ssdp:all"); send_packet();
        // Single byte packets at both extremes.
        pkt.delete(); pkt.push_back(8'hFF); send_packet();
        pkt.delete(); pkt.push_back(CHAR_NUL); send_packet();
        // Unmatched value.
        pkt.delete(); add_str("ST: foo"); add_crlf(); add_str("MX: 2"); add_crlf();
        send_packet();
        // Full request with high bytes and a short line after the ST line.
        pkt.delete(); add_str("M-SEARCH * HTTP/1.1"); add_crlf();
        add_str("ST:ssdp:all"); add_crlf(); add_str("MAN: x");
        pkt.push_back(8'hFF); pkt.push_back(8'h80); add_crlf();
        add_str("ST"); add_crlf(); send_packet();
        // Prefix of a target only.
        pkt.delete(); add_str("ST: ssdp:al"); add_crlf(); send_packet();
        // Empty ST value.
        pkt.delete(); add_str("ST:"); add_crlf(); add_crlf(); send_packet();
        // Broken prefixes.
        pkt.delete(); add_str("S:"); add_crlf(); add_str("SX: ssdp:all"); add_crlf();
        send_packet();
        // Last byte is a trailing CR.
        pkt.delete(); add_str("ST: ssdp:all"); pkt.push_back(CHAR_CR); send_packet();
    endtask

    // ------------------------------------------------------------------
    // Result receiver: its own stall pattern, plus one long hold-off once
    // the random phase is running so the block backs up into its input.
    // ------------------------------------------------------------------
    initial
    begin : result_drain
        drain_mode_e mode;
        int unsigned span;
        int unsigned pick;
        bit          squeezed;
        result.ready <= 1'b0;
        squeezed = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (random_phase && !squeezed)
            begin
                mode     = DRAIN_SHUT;
                span     = SQUEEZE_CYCLES;
                squeezed = 1'b1;
            end
            else
            begin
                pick = $urandom_range(0, 19);
                mode = (pick < 8) ? DRAIN_OPEN : (pick < 19) ? DRAIN_CHOPPY : DRAIN_SHUT;
                span = (mode == DRAIN_SHUT) ? $urandom_range(60, 200) : $urandom_range(4, 64);
            end
            while (span != 0)
            begin
                @(posedge clk);
                result.ready <= (mode == DRAIN_OPEN) ||
                                (mode == DRAIN_CHOPPY && $urandom_range(0, 2) != 0);
                span--;
            end
        end
    end

    // Cycle counter: end a hung run.
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < RUN_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("ssdp_search_target_classifier_tb: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, directed packets, random packets, drain, verdict.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        rst_n                 <= 1'b0;
        byte_stream.valid     <= 1'b0;
        byte_stream.text_byte <= '0;
        byte_stream.is_last   <= 1'b0;
        random_phase          <= 1'b0;
        burst_left     = 0;
        random_bytes   = 0;
        random_packets = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        random_phase <= 1'b1;
        while (random_bytes < RANDOM_BYTES_MIN || random_packets < RANDOM_PACKETS_MIN)
        begin
            build_random_packet();
            send_packet();
            random_bytes += pkt.size();
            random_packets++;
        end
        byte_stream.valid <= 1'b0;

        // Let the checker see the final transaction, then wait for the
        // last expected result and a short tail.
        @(posedge clk);
        while (open_count != 0) @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);

        if (fail_count == 0)
            $display("ssdp_search_target_classifier_tb: clean");
        else
            $display("ssdp_search_target_classifier_tb: errors");
        $finish;
    end

endmodule
`default_nettype wire

// File: ssdp_search_target_classifier.f
rtl/ssdpst_pkg.sv
rtl/ssdpst_in_if.sv
rtl/ssdpst_out_if.sv
rtl/ssdpst_in_reg.sv
rtl/ssdpst_scan.sv
rtl/ssdp_search_target_classifier.sv
dv/ssdpst_target_checker.sv
dv/ssdp_search_target_classifier_tb.sv
